FILE: design/ccrng_pkg.sv
// ----------------------------------------------------------------------------
// ccrng_pkg
// Shared types, constants and helpers for the buffered ChaCha random generator.
// ----------------------------------------------------------------------------
package ccrng_pkg;

  localparam int BUFFER_BLOCKS = 16;
  localparam int CHACHA_ROUNDS = 20;
  localparam int MAX_BYTES_PER_REQUEST = 64;

  // odd round counts run as whole double rounds
  localparam int ROUND_CNT = ((CHACHA_ROUNDS + 1) / 2) * 2;
  localparam int BLOCK_BYTES = 64;
  localparam int KEY_BYTES = 32;
  localparam int NONCE_BYTES = 8;
  localparam int STORE_BYTES = BUFFER_BLOCKS * BLOCK_BYTES;
  localparam int FRESH_BYTES = STORE_BYTES - KEY_BYTES - NONCE_BYTES;
  localparam int NUM_REGS = 5;

  localparam int POS_W = $clog2(STORE_BYTES);
  localparam int LEFT_W = POS_W + 1;
  localparam int WADDR_W = POS_W - 2;
  localparam int BLK_W = $clog2(BUFFER_BLOCKS);
  localparam int RND_W = $clog2(ROUND_CNT);
  localparam int CNT_W = 7;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 64;

  localparam logic [0:0] OP_WORD = 1'b0;
  localparam logic [0:0] OP_BYTES = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_KEY0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KEY2 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KEY3 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_NONCE = 3'd4;

  localparam logic [31:0] SIGMA0 = 32'h61707865;
  localparam logic [31:0] SIGMA1 = 32'h3320646e;
  localparam logic [31:0] SIGMA2 = 32'h79622d32;
  localparam logic [31:0] SIGMA3 = 32'h6b206574;

  typedef struct packed {
    logic [0:0] opcode;
    logic [CNT_W-1:0] byte_count;
  } req_t;

  typedef struct packed {
    logic [31:0] value;
    logic last;
  } result_t;

  // controller -> datapath
  typedef struct packed {
    logic x_load;
    logic x_round;
    logic [1:0] step;
    logic diag;
    logic st_write;
    logic [BLK_W-1:0] blk;
    logic [3:0] widx;
    logic commit;
    logic rd_issue;
    logic rd_take;
    logic op_byte;
    logic emit;
    logic last;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic left_zero;
    logic left_lt4;
  } status_t;

  function automatic logic [31:0] rotl32(input logic [31:0] v, input int s);
    return (v << s) | (v >> (32 - s));
  endfunction

endpackage

FILE: design/ccrng_ctrl.sv
// ----------------------------------------------------------------------------
// ccrng_ctrl
// Sequencer: request decode, rekey block/round/word counters, byte reads.
// ----------------------------------------------------------------------------
module ccrng_ctrl import ccrng_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  input  req_t    req,
  input  status_t status,
  output logic    busy,
  output cmd_t    cmd
);

  typedef enum logic [6:0] {
    IDLE      = 7'b0000001,
    RK_INIT   = 7'b0000010,
    RK_ROUND  = 7'b0000100,
    RK_WRITE  = 7'b0001000,
    RK_COMMIT = 7'b0010000,
    RD_ADDR   = 7'b0100000,
    RD_DATA   = 7'b1000000
  } state_t;

  state_t state, state_next;
  logic [1:0] step;
  logic [RND_W-1:0] round;
  logic [BLK_W-1:0] blk;
  logic [3:0] widx;
  logic op_byte;
  logic [CNT_W-1:0] total, cnt, cnt_next;
  logic [CNT_W-1:0] req_n;

  localparam logic [RND_W-1:0] LAST_ROUND = RND_W'(ROUND_CNT - 1);
  localparam logic [BLK_W-1:0] LAST_BLK = BLK_W'(BUFFER_BLOCKS - 1);
  localparam logic [CNT_W-1:0] MAX_N = CNT_W'(MAX_BYTES_PER_REQUEST);

  assign busy = (state != IDLE);
  assign cnt_next = cnt + 1'b1;
  assign req_n = (req.byte_count > MAX_N) ? MAX_N : req.byte_count;

  always_comb begin
    state_next = state;
    case (state)
      IDLE: begin
        if (start) begin
          if (req.opcode == OP_WORD) begin
            state_next = status.left_lt4 ? RK_INIT : RD_ADDR;
          end else if (req_n != '0) begin
            state_next = status.left_zero ? RK_INIT : RD_ADDR;
          end
        end
      end
      RK_INIT: state_next = RK_ROUND;
      RK_ROUND: begin
        if (step == 2'd3 && round == LAST_ROUND) state_next = RK_WRITE;
      end
      RK_WRITE: begin
        if (widx == 4'd15) state_next = (blk == LAST_BLK) ? RK_COMMIT : RK_INIT;
      end
      RK_COMMIT: state_next = (cnt != total) ? RD_ADDR : IDLE;
      RD_ADDR: state_next = RD_DATA;
      RD_DATA: begin
        if (op_byte && status.left_zero) state_next = RK_INIT;
        else if (cnt_next == total) state_next = IDLE;
        else state_next = RD_ADDR;
      end
      default: state_next = IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      step <= '0;
      round <= '0;
      blk <= '0;
      widx <= '0;
      op_byte <= 1'b0;
      total <= '0;
      cnt <= '0;
    end else begin
      state <= state_next;
      case (state)
        IDLE: begin
          if (start) begin
            op_byte <= (req.opcode == OP_BYTES);
            total <= (req.opcode == OP_WORD) ? CNT_W'(4) : req_n;
            cnt <= '0;
            blk <= '0;
          end
        end
        RK_INIT: begin
          step <= '0;
          round <= '0;
          widx <= '0;
        end
        RK_ROUND: begin
          step <= step + 1'b1;
          if (step == 2'd3) round <= round + 1'b1;
        end
        RK_WRITE: begin
          widx <= widx + 1'b1;
          if (widx == 4'd15) blk <= blk + 1'b1;
        end
        RK_COMMIT: blk <= '0;
        RD_DATA: begin
          cnt <= cnt_next;
          blk <= '0;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    cmd = '0;
    cmd.x_load = (state == RK_INIT);
    cmd.x_round = (state == RK_ROUND);
    cmd.step = step;
    cmd.diag = round[0];
    cmd.st_write = (state == RK_WRITE);
    cmd.blk = blk;
    cmd.widx = widx;
    cmd.commit = (state == RK_COMMIT);
    cmd.rd_issue = (state == RD_ADDR);
    cmd.rd_take = (state == RD_DATA);
    cmd.op_byte = op_byte;
    cmd.emit = (state == RD_DATA) && (op_byte || cnt_next == total);
    cmd.last = (cnt_next == total);
  end

endmodule

FILE: design/ccrng_datapath.sv
// ----------------------------------------------------------------------------
// ccrng_datapath
// Seed registers, ChaCha state with one quarter-round step per cycle,
// keystream store and byte/word read-out.
// ----------------------------------------------------------------------------
module ccrng_datapath import ccrng_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  cmd_t                  cmd,
  output status_t               status,
  output result_t               result,
  output logic                  result_valid
);

  logic [63:0] seed [NUM_REGS];
  logic [63:0] seed_upd [NUM_REGS];
  logic [31:0] key [8];
  logic [63:0] nonce;
  logic [31:0] new_key [8];
  logic [63:0] new_nonce;
  logic [31:0] init [16];
  logic [31:0] x [16];
  logic [31:0] x_next [16];
  logic [31:0] store [2**WADDR_W];
  logic [31:0] rdata;
  logic [1:0] sel;
  logic [LEFT_W-1:0] left;
  logic [LEFT_W-1:0] pos_full;
  logic [POS_W-1:0] pos;
  logic [31:0] acc;
  logic [31:0] out_word;
  logic [7:0] rd_byte;

  localparam logic [LEFT_W-1:0] STORE_L = LEFT_W'(STORE_BYTES);
  localparam logic [LEFT_W-1:0] FRESH_L = LEFT_W'(FRESH_BYTES);

  function automatic logic [3:0] qidx(input logic [1:0] j, input logic diag,
                                      input logic [1:0] row);
    logic [1:0] col;
    col = diag ? j + row : j;
    return {row, col};
  endfunction

  // seed write with the new value folded in, for the reload
  always_comb begin
    for (int i = 0; i < NUM_REGS; i++) seed_upd[i] = seed[i];
    if (cfg_we && cfg_index < CFG_IDX_W'(NUM_REGS))
      seed_upd[cfg_index] = cfg_data;
  end

  always_comb begin
    init[0] = SIGMA0;
    init[1] = SIGMA1;
    init[2] = SIGMA2;
    init[3] = SIGMA3;
    for (int i = 0; i < 8; i++) init[4+i] = key[i];
    init[12] = 32'(cmd.blk);
    init[13] = '0;
    init[14] = nonce[31:0];
    init[15] = nonce[63:32];
  end

  // four independent quarter-rounds, one add/xor/rotate step each
  always_comb begin
    logic [3:0] ia, ib, ic, id;
    logic [31:0] s;
    for (int i = 0; i < 16; i++) x_next[i] = x[i];
    for (int j = 0; j < 4; j++) begin
      ia = qidx(2'(j), cmd.diag, 2'd0);
      ib = qidx(2'(j), cmd.diag, 2'd1);
      ic = qidx(2'(j), cmd.diag, 2'd2);
      id = qidx(2'(j), cmd.diag, 2'd3);
      case (cmd.step)
        2'd0: begin
          s = x[ia] + x[ib];
          x_next[ia] = s;
          x_next[id] = rotl32(x[id] ^ s, 16);
        end
        2'd1: begin
          s = x[ic] + x[id];
          x_next[ic] = s;
          x_next[ib] = rotl32(x[ib] ^ s, 12);
        end
        2'd2: begin
          s = x[ia] + x[ib];
          x_next[ia] = s;
          x_next[id] = rotl32(x[id] ^ s, 8);
        end
        default: begin
          s = x[ic] + x[id];
          x_next[ic] = s;
          x_next[ib] = rotl32(x[ib] ^ s, 7);
        end
      endcase
    end
  end

  assign out_word = x[cmd.widx] + init[cmd.widx];

  always_ff @(posedge clk) begin
    if (cmd.x_load) begin
      for (int i = 0; i < 16; i++) x[i] <= init[i];
    end else if (cmd.x_round) begin
      for (int i = 0; i < 16; i++) x[i] <= x_next[i];
    end
  end

  // first 40 bytes of block zero become the next key and nonce
  always_ff @(posedge clk) begin
    if (cmd.st_write && cmd.blk == '0) begin
      if (cmd.widx < 4'd8) new_key[cmd.widx[2:0]] <= out_word;
      else if (cmd.widx == 4'd8) new_nonce[31:0] <= out_word;
      else if (cmd.widx == 4'd9) new_nonce[63:32] <= out_word;
    end
  end

  assign pos_full = STORE_L - left;
  assign pos = pos_full[POS_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.st_write) store[{cmd.blk, cmd.widx}] <= out_word;
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_issue) begin
      rdata <= store[pos[POS_W-1:2]];
      sel <= pos[1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_REGS; i++) seed[i] <= '0;
      for (int i = 0; i < 8; i++) key[i] <= '0;
      nonce <= '0;
      left <= '0;
    end else if (cfg_we && cfg_index < CFG_IDX_W'(NUM_REGS)) begin
      for (int i = 0; i < NUM_REGS; i++) seed[i] <= seed_upd[i];
      for (int i = 0; i < 4; i++) begin
        key[2*i] <= seed_upd[i][31:0];
        key[2*i+1] <= seed_upd[i][63:32];
      end
      nonce <= seed_upd[REG_NONCE];
      left <= '0;
    end else if (cmd.commit) begin
      for (int i = 0; i < 8; i++) key[i] <= new_key[i];
      nonce <= new_nonce;
      left <= FRESH_L;
    end else if (cmd.rd_issue) begin
      left <= left - 1'b1;
    end
  end

  assign status.left_zero = (left == '0);
  assign status.left_lt4 = (left < LEFT_W'(4));

  assign rd_byte = rdata[8*sel +: 8];

  always_ff @(posedge clk) begin
    if (cmd.rd_take) acc <= {rd_byte, acc[31:8]};
    if (cmd.emit) begin
      result.value <= cmd.op_byte ? {24'd0, rd_byte} : {rd_byte, acc[31:8]};
      result.last <= cmd.last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) result_valid <= 1'b0;
    else result_valid <= cmd.emit;
  end

endmodule

FILE: design/chacha_buffered_random_generator.sv
// ----------------------------------------------------------------------------
// chacha_buffered_random_generator
// Fast-key-erasure ChaCha20 random generator with a 1 KiB keystream buffer.
// ----------------------------------------------------------------------------
// Use:
//   Seed: cfg_we/cfg_index/cfg_data write key_word0..3 (index 0..3) and
//   nonce_seed (index 4). Any seed write reloads key and nonce and empties
//   the buffer. Write only while busy is low. Other indexes are ignored.
//   Request: raise start with req while busy is low. opcode 0 returns one
//   little-endian word, opcode 1 returns byte_count bytes (capped at 64),
//   one per result, value[7:0]. A zero count returns nothing.
//   Results: result_valid pulses one cycle per result; result.last marks
//   the final one. The receiver cannot stall the block.
// Sequence:
//   Each byte read is a store read, then a byte select; a word gathers
//   four bytes and its result shows in the cycle after the final select.
//   A rekey (buffer empty) runs 16 blocks, each a state load, the
//   quarter-round steps and the store of its 16 words, then a commit.
//   The ChaCha state updates one add/xor/rotate step per cycle.
// Reset: clears seeds, key, nonce and the fill count; the first request
//   that returns data rekeys first. No clearing pass on the store.
module chacha_buffered_random_generator import ccrng_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  start,
  input  req_t                  req,
  output logic                  busy,
  output result_t               result,
  output logic                  result_valid
);

  cmd_t    cmd;
  status_t status;

  // sequencer: request decode and rekey/read counters
  ccrng_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .req    (req),
    .status (status),
    .busy   (busy),
    .cmd    (cmd)
  );

  // cipher state, keystream store, output register
  ccrng_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .cmd          (cmd),
    .status       (status),
    .result       (result),
    .result_valid (result_valid)
  );

endmodule
